// File: rtl/core/ffgp_pkg.sv
// Shared constants, codes and types of the frame flip / gray / posterize unit.
package ffgp_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DIM_W      = 9;

    // Pixel format
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;

    // Posterize levels and derived step / reciprocal
    localparam int LVL_W       = 9;
    localparam int LEVELS_MIN  = 2;
    localparam int LEVELS_MAX  = 256;
    localparam int STEP_W      = 8;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Shared sequential divider
    localparam int DIV_W     = 16;
    localparam int DVS_W     = 9;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Grayscale divide by three: sum * 683 >> 11
    localparam int SUM_W       = 10;
    localparam int GRAY_RECIP  = 683;
    localparam int GRAY_SHIFT  = 11;

    // APB port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_VFLIP = 2'd0,
        MODE_HFLIP = 2'd1,
        MODE_GRAY  = 2'd2,
        MODE_POST  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_LEVELS = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_STEP,
        DIV_RECIP
    } div_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC
    } fetch_state_t;

    // Configuration and status from the register block
    typedef struct packed {
        mode_t              mode;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [LVL_W-1:0]   levels;
        logic [STEP_W-1:0]  step;
        logic [RECIP_W-1:0] recip;
        logic               busy;
        logic               geom_wr;
    } cfg_t;

endpackage

// File: rtl/core/ffgp_frame_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
module ffgp_frame_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ffgp_regs.sv
// APB register file with the sequential divider for posterize step and reciprocal.
module ffgp_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffgp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ffgp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ffgp_pkg::APB_DATA_W-1:0]     prdata,
    output ffgp_pkg::cfg_t                      cfg
);

    ffgp_pkg::reg_idx_t                   reg_idx;
    logic                                 wr_en;
    logic                                 lv_wr;
    logic [ffgp_pkg::DIM_W-1:0]           wval;
    logic [ffgp_pkg::DIM_W-1:0]           width_clamp;
    logic [ffgp_pkg::DIM_W-1:0]           height_clamp;
    logic [ffgp_pkg::LVL_W-1:0]           levels_clamp;

    ffgp_pkg::mode_t                      mode_reg;
    logic [ffgp_pkg::DIM_W-1:0]           width_reg;
    logic [ffgp_pkg::DIM_W-1:0]           height_reg;
    logic [ffgp_pkg::LVL_W-1:0]           levels_reg;
    logic [ffgp_pkg::STEP_W-1:0]          step_reg;
    logic [ffgp_pkg::RECIP_W-1:0]         recip_reg;

    ffgp_pkg::div_state_t                 div_state_reg;
    ffgp_pkg::div_state_t                 div_state_next;
    logic [ffgp_pkg::DIV_W-1:0]           dvd_reg;
    logic [ffgp_pkg::DVS_W-1:0]           rem_reg;
    logic [ffgp_pkg::DVS_W-1:0]           dvs_reg;
    logic [ffgp_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [ffgp_pkg::DVS_W:0]             trial;
    logic                                 ge;
    logic [ffgp_pkg::DVS_W:0]             rem_diff;
    logic [ffgp_pkg::DIV_W-1:0]           quo_step;
    logic [ffgp_pkg::DVS_W-1:0]           rem_step;
    logic                                 div_last;
    logic                                 busy;

    assign reg_idx = ffgp_pkg::reg_idx_t'(paddr[ffgp_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign lv_wr   = wr_en && (reg_idx == ffgp_pkg::REG_LEVELS);
    assign wval    = pwdata[ffgp_pkg::DIM_W-1:0];

    // Range clamps applied on write
    always_comb
    begin
        if (wval == '0)
            width_clamp = ffgp_pkg::DIM_W'(1);
        else if (wval > ffgp_pkg::DIM_W'(ffgp_pkg::MAX_WIDTH))
            width_clamp = ffgp_pkg::DIM_W'(ffgp_pkg::MAX_WIDTH);
        else
            width_clamp = wval;

        if (wval == '0)
            height_clamp = ffgp_pkg::DIM_W'(1);
        else if (wval > ffgp_pkg::DIM_W'(ffgp_pkg::MAX_HEIGHT))
            height_clamp = ffgp_pkg::DIM_W'(ffgp_pkg::MAX_HEIGHT);
        else
            height_clamp = wval;

        if (wval < ffgp_pkg::LVL_W'(ffgp_pkg::LEVELS_MIN))
            levels_clamp = ffgp_pkg::LVL_W'(ffgp_pkg::LEVELS_MIN);
        else if (wval > ffgp_pkg::LVL_W'(ffgp_pkg::LEVELS_MAX))
            levels_clamp = ffgp_pkg::LVL_W'(ffgp_pkg::LEVELS_MAX);
        else
            levels_clamp = wval;
    end

    // Restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, dvd_reg[ffgp_pkg::DIV_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_diff = trial - {1'b0, dvs_reg};
    assign rem_step = ge ? rem_diff[ffgp_pkg::DVS_W-1:0] : trial[ffgp_pkg::DVS_W-1:0];
    assign quo_step = {dvd_reg[ffgp_pkg::DIV_W-2:0], ge};
    assign div_last = (cnt_reg == ffgp_pkg::DIV_CNT_W'(ffgp_pkg::DIV_W - 1));

    // Divider sequencer: step = 256 / levels, then recip = 65535 / step + 1
    always_comb
    begin
        div_state_next = div_state_reg;
        if (lv_wr)
        begin
            div_state_next = ffgp_pkg::DIV_STEP;
        end
        else
        begin
            unique case (div_state_reg)
                ffgp_pkg::DIV_IDLE:  div_state_next = ffgp_pkg::DIV_IDLE;
                ffgp_pkg::DIV_STEP:  if (div_last) div_state_next = ffgp_pkg::DIV_RECIP;
                ffgp_pkg::DIV_RECIP: if (div_last) div_state_next = ffgp_pkg::DIV_IDLE;
                default:             div_state_next = ffgp_pkg::DIV_IDLE;
            endcase
        end
    end

    always_comb
    begin
        busy = (div_state_reg != ffgp_pkg::DIV_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ffgp_pkg::MODE_VFLIP;
            width_reg     <= ffgp_pkg::DIM_W'(ffgp_pkg::MAX_WIDTH);
            height_reg    <= ffgp_pkg::DIM_W'(ffgp_pkg::MAX_HEIGHT);
            levels_reg    <= ffgp_pkg::LVL_W'(ffgp_pkg::LEVELS_MAX);
            step_reg      <= ffgp_pkg::STEP_W'(1);
            recip_reg     <= ffgp_pkg::RECIP_W'(1) << ffgp_pkg::RECIP_SHIFT;
            div_state_reg <= ffgp_pkg::DIV_IDLE;
        end
        else
        begin
            div_state_reg <= div_state_next;
            if (wr_en)
            begin
                unique case (reg_idx)
                    ffgp_pkg::REG_MODE:
                        mode_reg <= ffgp_pkg::mode_t'(pwdata[1:0]);
                    ffgp_pkg::REG_WIDTH:
                        width_reg <= width_clamp;
                    ffgp_pkg::REG_HEIGHT:
                        height_reg <= height_clamp;
                    ffgp_pkg::REG_LEVELS:
                        levels_reg <= levels_clamp;
                    default:
                        ;
                endcase
            end
            if (!lv_wr && div_last)
            begin
                if (div_state_reg == ffgp_pkg::DIV_STEP)
                    step_reg <= quo_step[ffgp_pkg::STEP_W-1:0];
                else if (div_state_reg == ffgp_pkg::DIV_RECIP)
                    recip_reg <= ffgp_pkg::RECIP_W'(quo_step) + ffgp_pkg::RECIP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lv_wr)
        begin
            dvd_reg <= ffgp_pkg::DIV_W'(ffgp_pkg::LEVELS_MAX);
            rem_reg <= '0;
            dvs_reg <= levels_clamp;
            cnt_reg <= '0;
        end
        else if (busy)
        begin
            if (div_last)
            begin
                // second pass divides 65535 by the fresh step
                dvd_reg <= '1;
                rem_reg <= '0;
                dvs_reg <= ffgp_pkg::DVS_W'(quo_step[ffgp_pkg::STEP_W-1:0]);
                cnt_reg <= '0;
            end
            else
            begin
                dvd_reg <= quo_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg + ffgp_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ffgp_pkg::REG_MODE:   prdata = ffgp_pkg::APB_DATA_W'(mode_reg);
            ffgp_pkg::REG_WIDTH:  prdata = ffgp_pkg::APB_DATA_W'(width_reg);
            ffgp_pkg::REG_HEIGHT: prdata = ffgp_pkg::APB_DATA_W'(height_reg);
            ffgp_pkg::REG_LEVELS: prdata = ffgp_pkg::APB_DATA_W'(levels_reg);
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.mode    = mode_reg;
        cfg.width   = width_reg;
        cfg.height  = height_reg;
        cfg.levels  = levels_reg;
        cfg.step    = step_reg;
        cfg.recip   = recip_reg;
        cfg.busy    = busy;
        cfg.geom_wr = wr_en && ((reg_idx == ffgp_pkg::REG_WIDTH) ||
                                (reg_idx == ffgp_pkg::REG_HEIGHT));
    end

endmodule

// File: rtl/core/ffgp_xform.sv
// Pixel transform: grayscale average, posterize or pass-through, with a registered multiply stage.
module ffgp_xform (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ffgp_pkg::PIX_W-1:0]    pix_in,
    input  ffgp_pkg::cfg_t                cfg,
    output logic [ffgp_pkg::PIX_W-1:0]    pix_out
);

    localparam int PROD_W  = ffgp_pkg::CH_W + ffgp_pkg::RECIP_W;
    localparam int GPROD_W = 2 * ffgp_pkg::SUM_W;
    localparam int PP_W    = ffgp_pkg::STEP_W + ffgp_pkg::CH_W;

    logic [ffgp_pkg::NUM_CH-1:0][ffgp_pkg::CH_W-1:0] ch_in;
    logic [ffgp_pkg::NUM_CH-1:0][ffgp_pkg::CH_W-1:0] ch_x;
    logic [ffgp_pkg::NUM_CH-1:0][PROD_W-1:0]         lane_prod;
    logic [ffgp_pkg::NUM_CH-1:0][ffgp_pkg::CH_W-1:0] q_next;
    logic [ffgp_pkg::NUM_CH-1:0]                     zero_next;
    logic [ffgp_pkg::SUM_W-1:0]                      sum;
    logic [GPROD_W-1:0]                              gprod;

    logic [ffgp_pkg::PIX_W-1:0]                      pix_reg;
    logic [ffgp_pkg::NUM_CH-1:0][ffgp_pkg::CH_W-1:0] q_reg;
    logic [ffgp_pkg::NUM_CH-1:0]                     zero_reg;
    logic [ffgp_pkg::CH_W-1:0]                       gray_reg;

    logic [ffgp_pkg::LVL_W-1:0]                      lm1_full;
    logic [ffgp_pkg::CH_W-1:0]                       lm1;
    logic [ffgp_pkg::NUM_CH-1:0][ffgp_pkg::CH_W-1:0] qc;
    logic [ffgp_pkg::NUM_CH-1:0][PP_W-1:0]           pp;
    logic [ffgp_pkg::NUM_CH-1:0][ffgp_pkg::CH_W-1:0] post;

    assign ch_in = pix_in;

    // Stage 1: (v-1) div step by reciprocal multiply, one lane per channel
    always_comb
    begin
        for (int i = 0; i < ffgp_pkg::NUM_CH; i++)
        begin
            ch_x[i]      = ch_in[i] - ffgp_pkg::CH_W'(1);
            lane_prod[i] = PROD_W'(ch_x[i]) * PROD_W'(cfg.recip);
            q_next[i]    = lane_prod[i][ffgp_pkg::RECIP_SHIFT +: ffgp_pkg::CH_W];
            zero_next[i] = (ch_in[i] == '0);
        end
        sum   = ffgp_pkg::SUM_W'(ch_in[0]) + ffgp_pkg::SUM_W'(ch_in[1]) +
                ffgp_pkg::SUM_W'(ch_in[2]);
        gprod = GPROD_W'(sum) * GPROD_W'(ffgp_pkg::GRAY_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg  <= pix_in;
            q_reg    <= q_next;
            zero_reg <= zero_next;
            gray_reg <= gprod[ffgp_pkg::GRAY_SHIFT +: ffgp_pkg::CH_W];
        end
    end

    // Stage 2: clamp quotient to levels-1, scale back by step
    assign lm1_full = cfg.levels - ffgp_pkg::LVL_W'(1);
    assign lm1      = lm1_full[ffgp_pkg::CH_W-1:0];

    always_comb
    begin
        for (int i = 0; i < ffgp_pkg::NUM_CH; i++)
        begin
            qc[i]   = (q_reg[i] > lm1) ? lm1 : q_reg[i];
            pp[i]   = PP_W'(cfg.step) * PP_W'(qc[i]);
            post[i] = zero_reg[i] ? '0 : pp[i][ffgp_pkg::CH_W-1:0];
        end

        case (cfg.mode)
            ffgp_pkg::MODE_GRAY: pix_out = {gray_reg, gray_reg, gray_reg};
            ffgp_pkg::MODE_POST: pix_out = post;
            default:             pix_out = pix_reg;
        endcase
    end

endmodule

// File: rtl/core/frame_flip_gray_posterize_unit.sv
// Top level of the frame flip / gray / posterize unit: sequencer, counters, output register.
// A fetch result passes the frame RAM read register and the transform register into the output register.
// Throughput: loads 1 per cycle while the divider is idle; no fetch is taken while a fetch is
//   in the read stage; a new one is taken in CALC as the result enters the output register.
// A levels write holds off input while the shared divider derives step and recip.
// Reset clears state, counters, frame-ready and out_valid, presets config; RAM is not cleared.
module frame_flip_gray_posterize_unit (
    input  logic                              clk,
    input  logic                              rst_n,

    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ffgp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ffgp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ffgp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,

    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [ffgp_pkg::CH_W-1:0]         in_red,
    input  logic [ffgp_pkg::CH_W-1:0]         in_green,
    input  logic [ffgp_pkg::CH_W-1:0]         in_blue,

    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ffgp_pkg::CH_W-1:0]         out_red,
    output logic [ffgp_pkg::CH_W-1:0]         out_green,
    output logic [ffgp_pkg::CH_W-1:0]         out_blue,
    output logic                              frame_end
);

    ffgp_pkg::cfg_t                   cfg;

    ffgp_pkg::fetch_state_t           state_reg;
    ffgp_pkg::fetch_state_t           state_next;

    // load / fetch positions and frame-ready flag
    logic [ffgp_pkg::ROW_W-1:0]       load_row_reg;
    logic [ffgp_pkg::ROW_W-1:0]       load_row_next;
    logic [ffgp_pkg::COL_W-1:0]       load_col_reg;
    logic [ffgp_pkg::COL_W-1:0]       load_col_next;
    logic [ffgp_pkg::ROW_W-1:0]       fetch_row_reg;
    logic [ffgp_pkg::ROW_W-1:0]       fetch_row_next;
    logic [ffgp_pkg::COL_W-1:0]       fetch_col_reg;
    logic [ffgp_pkg::COL_W-1:0]       fetch_col_next;
    logic                             frame_ready_reg;
    logic                             frame_ready_next;

    logic                             accept;
    logic                             load_go;
    logic                             fetch_go;
    logic                             out_free;
    logic                             xf_en;
    logic                             out_load;
    logic                             in_ready_int;

    logic [ffgp_pkg::DIM_W-1:0]       load_col_inc;
    logic [ffgp_pkg::DIM_W-1:0]       load_row_inc;
    logic [ffgp_pkg::DIM_W-1:0]       fetch_col_inc;
    logic [ffgp_pkg::DIM_W-1:0]       fetch_row_inc;
    logic [ffgp_pkg::DIM_W-1:0]       vrow;
    logic [ffgp_pkg::DIM_W-1:0]       hcol;
    logic [ffgp_pkg::ROW_W-1:0]       src_row;
    logic [ffgp_pkg::COL_W-1:0]       src_col;
    logic                             fetch_last;

    logic [ffgp_pkg::ADDR_W-1:0]      waddr;
    logic [ffgp_pkg::ADDR_W-1:0]      raddr;
    logic [ffgp_pkg::PIX_W-1:0]       wdata;
    logic [ffgp_pkg::PIX_W-1:0]       rdata;
    logic [ffgp_pkg::PIX_W-1:0]       xf_pix;

    // frame_end follows its fetch through the read and multiply stages
    logic                             last_rd_reg;
    logic                             last_calc_reg;

    logic                             out_valid_reg;
    logic [ffgp_pkg::PIX_W-1:0]       out_pix_reg;
    logic                             out_last_reg;

    assign pready = 1'b1;

    ffgp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Transaction decode. A fetch before a full frame is taken and dropped.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready_int;
    assign load_go  = accept && !func;
    assign fetch_go = accept && func && frame_ready_reg;
    assign in_ready = in_ready_int;

    // ------------------------------------------------------------------
    // Fetch sequencer: IDLE -> READ (RAM data registered) -> CALC (result
    // into output register). A new transaction is taken in CALC as the
    // result leaves, so a following fetch goes straight back to READ.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffgp_pkg::ST_IDLE:
                if (fetch_go) state_next = ffgp_pkg::ST_READ;
            ffgp_pkg::ST_READ:
                state_next = ffgp_pkg::ST_CALC;
            ffgp_pkg::ST_CALC:
                if (out_free) state_next = fetch_go ? ffgp_pkg::ST_READ : ffgp_pkg::ST_IDLE;
            default:
                state_next = ffgp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready_int = 1'b0;
        xf_en        = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ffgp_pkg::ST_IDLE:
                in_ready_int = !cfg.busy;
            ffgp_pkg::ST_READ:
                xf_en = 1'b1;
            ffgp_pkg::ST_CALC:
            begin
                in_ready_int = !cfg.busy && out_free;
                out_load     = out_free;
            end
            default:
                ;
        endcase
    end

    // ------------------------------------------------------------------
    // Position counters. Counters always stay inside the frame, since a
    // geometry write zeroes them all.
    // ------------------------------------------------------------------
    assign load_col_inc  = ffgp_pkg::DIM_W'(load_col_reg) + ffgp_pkg::DIM_W'(1);
    assign load_row_inc  = ffgp_pkg::DIM_W'(load_row_reg) + ffgp_pkg::DIM_W'(1);
    assign fetch_col_inc = ffgp_pkg::DIM_W'(fetch_col_reg) + ffgp_pkg::DIM_W'(1);
    assign fetch_row_inc = ffgp_pkg::DIM_W'(fetch_row_reg) + ffgp_pkg::DIM_W'(1);

    always_comb
    begin
        load_row_next    = load_row_reg;
        load_col_next    = load_col_reg;
        fetch_row_next   = fetch_row_reg;
        fetch_col_next   = fetch_col_reg;
        frame_ready_next = frame_ready_reg;

        if (cfg.geom_wr)
        begin
            load_row_next    = '0;
            load_col_next    = '0;
            fetch_row_next   = '0;
            fetch_col_next   = '0;
            frame_ready_next = 1'b0;
        end
        else if (load_go)
        begin
            // loading onto a ready frame starts a new one
            if (frame_ready_reg)
            begin
                fetch_row_next = '0;
                fetch_col_next = '0;
            end
            frame_ready_next = 1'b0;
            if (load_col_inc >= cfg.width)
            begin
                load_col_next = '0;
                if (load_row_inc >= cfg.height)
                begin
                    load_row_next    = '0;
                    frame_ready_next = 1'b1;
                    fetch_row_next   = '0;
                    fetch_col_next   = '0;
                end
                else
                begin
                    load_row_next = load_row_inc[ffgp_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                load_col_next = load_col_inc[ffgp_pkg::COL_W-1:0];
            end
        end
        else if (fetch_go)
        begin
            // raster walk that wraps after the last pixel
            if (fetch_col_inc >= cfg.width)
            begin
                fetch_col_next = '0;
                if (fetch_row_inc >= cfg.height)
                    fetch_row_next = '0;
                else
                    fetch_row_next = fetch_row_inc[ffgp_pkg::ROW_W-1:0];
            end
            else
            begin
                fetch_col_next = fetch_col_inc[ffgp_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ffgp_pkg::ST_IDLE;
            load_row_reg    <= '0;
            load_col_reg    <= '0;
            fetch_row_reg   <= '0;
            fetch_col_reg   <= '0;
            frame_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_row_reg    <= load_row_next;
            load_col_reg    <= load_col_next;
            fetch_row_reg   <= fetch_row_next;
            fetch_col_reg   <= fetch_col_next;
            frame_ready_reg <= frame_ready_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Frame RAM addressing. Flips are applied on the read address. A load
    // and a fetch never share a cycle, so no write-to-read bypass is needed.
    // ------------------------------------------------------------------
    assign vrow = cfg.height - ffgp_pkg::DIM_W'(1) - ffgp_pkg::DIM_W'(fetch_row_reg);
    assign hcol = cfg.width - ffgp_pkg::DIM_W'(1) - ffgp_pkg::DIM_W'(fetch_col_reg);

    always_comb
    begin
        src_row = fetch_row_reg;
        src_col = fetch_col_reg;
        case (cfg.mode)
            ffgp_pkg::MODE_VFLIP: src_row = vrow[ffgp_pkg::ROW_W-1:0];
            ffgp_pkg::MODE_HFLIP: src_col = hcol[ffgp_pkg::COL_W-1:0];
            default:              ;
        endcase
    end

    assign fetch_last = (ffgp_pkg::DIM_W'(fetch_row_reg) == cfg.height - ffgp_pkg::DIM_W'(1)) &&
                        (ffgp_pkg::DIM_W'(fetch_col_reg) == cfg.width - ffgp_pkg::DIM_W'(1));

    assign waddr = ffgp_pkg::ADDR_W'(load_row_reg) * ffgp_pkg::ADDR_W'(ffgp_pkg::MAX_WIDTH) +
                   ffgp_pkg::ADDR_W'(load_col_reg);
    assign raddr = ffgp_pkg::ADDR_W'(src_row) * ffgp_pkg::ADDR_W'(ffgp_pkg::MAX_WIDTH) +
                   ffgp_pkg::ADDR_W'(src_col);
    assign wdata = {in_red, in_green, in_blue};

    ffgp_frame_ram #(
        .DATA_W (ffgp_pkg::PIX_W),
        .ADDR_W (ffgp_pkg::ADDR_W)
    ) u_frame_ram (
        .clk   (clk),
        .we    (load_go),
        .waddr (waddr),
        .wdata (wdata),
        .re    (fetch_go),
        .raddr (raddr),
        .rdata (rdata)
    );

    ffgp_xform u_xform (
        .clk     (clk),
        .en      (xf_en),
        .pix_in  (rdata),
        .cfg     (cfg),
        .pix_out (xf_pix)
    );

    // ------------------------------------------------------------------
    // Output register; parts the output handshake from the sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (fetch_go)
            last_rd_reg <= fetch_last;
        if (xf_en)
            last_calc_reg <= last_rd_reg;
        if (out_load)
        begin
            out_pix_reg  <= xf_pix;
            out_last_reg <= last_calc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_pix_reg[2*ffgp_pkg::CH_W +: ffgp_pkg::CH_W];
    assign out_green = out_pix_reg[ffgp_pkg::CH_W +: ffgp_pkg::CH_W];
    assign out_blue  = out_pix_reg[0 +: ffgp_pkg::CH_W];
    assign frame_end = out_last_reg;

`ifndef SYNTHESIS
    // a result only appears after the calc stage
    a_out_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ffgp_pkg::ST_CALC))
        else $error("result appeared without a calc stage");

    // the read stage always hands over to calc
    a_read_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffgp_pkg::ST_READ) |=> (state_reg == ffgp_pkg::ST_CALC))
        else $error("read stage did not advance");

    // load position stays inside the configured frame
    a_load_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (ffgp_pkg::DIM_W'(load_row_reg) < cfg.height) &&
        (ffgp_pkg::DIM_W'(load_col_reg) < cfg.width))
        else $error("load position outside frame");

    // fetch position stays inside the configured frame
    a_fetch_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (ffgp_pkg::DIM_W'(fetch_row_reg) < cfg.height) &&
        (ffgp_pkg::DIM_W'(fetch_col_reg) < cfg.width))
        else $error("fetch position outside frame");
`endif

endmodule
